/* design/dr_pkg.sv */
// dr_pkg: widths, register indexes and the pipeline tag shared by the
// disparity reprojection block. No dependencies.
`default_nettype none
package dr_pkg;

    localparam int COORD_W = 12;      // pixel_col / pixel_row field width
    localparam int CODE_W  = 16;      // code_u / code_v field width
    localparam int DISP_W  = 24;      // disparity field width
    localparam int CFG_W   = 64;      // configuration register width
    localparam int CIDX_W  = 3;       // configuration index width
    localparam int COEF_W  = 32;      // one Q8.24 coefficient

    localparam int PW  = 49;          // coefficient times code
    localparam int KW  = 47;          // coefficient times 16000
    localparam int TW  = 51;          // linear terms and A
    localparam int XPW = 38;          // coordinate partial products
    localparam int C3W = 61;          // 1000 times term 3
    localparam int BW  = 70;          // B
    localparam int NW  = 122;         // numerator
    localparam int DW  = 103;         // denominator
    localparam int CW  = 132;         // divider datapath
    localparam int QB  = 25;          // quotient bits before rounding

    localparam logic [CIDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
    localparam logic [CIDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
    localparam logic [CIDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
    localparam logic [CIDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
    localparam logic [CIDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
    localparam logic [CIDX_W-1:0] REG_ROW2_COLS23 = 3'd5;

    localparam logic [QB:0] LIM_POS = 26'h07FFFFF;
    localparam logic [QB:0] LIM_NEG = 26'h0800000;

    typedef struct packed {
        logic valid;
        logic neg;
        logic dead;
        logic sat;
    } dr_tag_t;

endpackage
`default_nettype wire

/* design/dr_in_if.sv */
// dr_in_if: pixel channel (valid/ready plus coordinates and codes).
// Depends on dr_pkg for field widths.
`default_nettype none
interface dr_in_if;
    logic                         valid;
    logic                         ready;
    logic [dr_pkg::COORD_W-1:0]   pixel_col;
    logic [dr_pkg::COORD_W-1:0]   pixel_row;
    logic [dr_pkg::CODE_W-1:0]    code_u;
    logic [dr_pkg::CODE_W-1:0]    code_v;
    logic                         u_known;
    logic                         v_known;

    modport source (output valid, pixel_col, pixel_row, code_u, code_v, u_known, v_known,
                    input ready);
    modport sink   (input valid, pixel_col, pixel_row, code_u, code_v, u_known, v_known,
                    output ready);
endinterface
`default_nettype wire

/* design/dr_out_if.sv */
// dr_out_if: disparity result channel (valid/ready plus disparity word).
// Depends on dr_pkg for field widths.
`default_nettype none
interface dr_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [dr_pkg::DISP_W-1:0] disparity;
    logic                             disp_valid;

    modport source (output valid, disparity, disp_valid, input ready);
    modport sink   (input valid, disparity, disp_valid, output ready);
endinterface
`default_nettype wire

/* design/dr_div.sv */
// dr_div: pipelined restoring divider, one quotient bit per stage, with
// overflow detect and round-half-up on the remainder. Depends on dr_pkg.
`default_nettype none
module dr_div
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    en,
    input  wire dr_pkg::dr_tag_t         tag_i,
    input  wire logic [dr_pkg::CW-1:0]   num_i,
    input  wire logic [dr_pkg::CW-1:0]   den_i,
    output dr_pkg::dr_tag_t              tag_o,
    output logic [dr_pkg::QB:0]          quot_o
);

    localparam int CW = dr_pkg::CW;
    localparam int QB = dr_pkg::QB;

    dr_pkg::dr_tag_t  tag_reg [QB+1];
    logic [CW-1:0]    rem_reg [QB+1];
    logic [CW-1:0]    den_reg [QB+1];
    logic [QB-1:0]    q_reg   [QB+1];
    dr_pkg::dr_tag_t  tag_out_reg;
    logic [QB:0]      quot_reg;

    dr_pkg::dr_tag_t  tag_next;
    logic [CW-1:0]    den_top;
    logic             round_up;

    // quotient of 2^QB or more saturates anyway
    always_comb
    begin
        den_top  = den_i << QB;
        tag_next = tag_i;
        tag_next.sat = (num_i >= den_top);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg[0] <= '0;
        end
        else if (en)
        begin
            tag_reg[0] <= tag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= num_i;
            den_reg[0] <= den_i;
            q_reg[0]   <= '0;
        end
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_step
        logic [CW-1:0] dsh;
        logic          take;
        assign dsh  = den_reg[k] << (QB - 1 - k);
        assign take = (rem_reg[k] >= dsh);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tag_reg[k+1] <= '0;
            end
            else if (en)
            begin
                tag_reg[k+1] <= tag_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1] <= take ? (rem_reg[k] - dsh) : rem_reg[k];
                den_reg[k+1] <= den_reg[k];
                q_reg[k+1]   <= {q_reg[k][QB-2:0], take};
            end
        end
    end

    assign round_up = ((rem_reg[QB] << 1) >= den_reg[QB]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_out_reg <= '0;
        end
        else if (en)
        begin
            tag_out_reg <= tag_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg <= {1'b0, q_reg[QB]} + {{QB{1'b0}}, round_up};
        end
    end

    assign tag_o  = tag_out_reg;
    assign quot_o = quot_reg;

endmodule
`default_nettype wire

/* design/disparity_reprojection.sv */
// disparity_reprojection: top level. Projection matrix registers, the
// least-squares datapath and output register. Depends on dr_pkg, dr_in_if,
// dr_out_if and dr_div.
//
// Use: pixel words enter on the "pixel" channel (valid/ready), one result
// word per pixel leaves on the "result" channel in the same order. The six
// matrix registers are written through cfg_we/cfg_index/cfg_data while the
// block is idle; indexes above five are ignored.
// Throughput: one pixel per clock when not stalled. The datapath is one pipeline of
// 37 register stages: nine for the products and sums that build N and D
// (wide products split into partial products over two stages), one for the
// overflow check, 25 for the restoring divider (one quotient bit per
// stage), one for rounding and one output register.
// Reset clears the matrix registers to zero and empties the pipeline.
// Stall: while a result word waits and the receiver holds ready low, every
// stage holds and pixel.ready is low; nothing is dropped or repeated.
`default_nettype none
module disparity_reprojection
#(
    parameter int COORD_BITS = 12
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    dr_in_if.sink                              pixel,
    dr_out_if.source                           result,
    input  wire logic                          cfg_we,
    input  wire logic [dr_pkg::CIDX_W-1:0]     cfg_index,
    input  wire logic [dr_pkg::CFG_W-1:0]      cfg_data
);

    localparam int XW  = dr_pkg::COORD_W;
    localparam int UW  = dr_pkg::CODE_W;
    localparam int PW  = dr_pkg::PW;
    localparam int KW  = dr_pkg::KW;
    localparam int TW  = dr_pkg::TW;
    localparam int XPW = dr_pkg::XPW;
    localparam int C3W = dr_pkg::C3W;
    localparam int BW  = dr_pkg::BW;
    localparam int NW  = dr_pkg::NW;
    localparam int DW  = dr_pkg::DW;
    localparam int CW  = dr_pkg::CW;
    localparam int QB  = dr_pkg::QB;
    localparam int DSW = dr_pkg::DISP_W;
    localparam logic [XW-1:0] XMASK =
        (COORD_BITS >= XW) ? {XW{1'b1}} : XW'((1 << COORD_BITS) - 1);

    logic                      adv;
    logic [dr_pkg::CFG_W-1:0]  cfg_reg [6];
    logic signed [31:0]        m  [3][4];
    logic signed [KW-1:0]      kc [2][4];

    logic [8:0]                vld_reg;
    // stage 1
    logic [XW-1:0]             x1_reg, y1_reg;
    logic [UW-1:0]             code1_reg [2];
    logic                      kn1_reg;
    // stage 2
    logic signed [PW-1:0]      p2_reg [2][4];
    logic [XW-1:0]             x2_reg, y2_reg;
    logic                      kn2_reg;
    // stage 3: index 2 holds A
    logic signed [TW-1:0]      t3_reg [2][4];
    logic [XW-1:0]             x3_reg, y3_reg;
    logic                      kn3_reg;
    // stage 4
    logic signed [XPW-1:0]     xh4_reg [2], yh4_reg [2];
    logic [XPW-1:0]            xl4_reg [2], yl4_reg [2];
    logic signed [C3W-1:0]     c34_reg [2];
    logic signed [TW-1:0]      a4_reg [2];
    logic                      kn4_reg;
    // stage 5
    logic signed [BW-1:0]      b5_reg [2];
    logic signed [TW-1:0]      a5_reg [2];
    logic                      kn5_reg;
    // stage 6: partial products
    logic [60:0]               p00_reg [2];
    logic signed [61:0]        p01_reg [2];
    logic signed [60:0]        p10_reg [2];
    logic signed [59:0]        p11_reg [2];
    logic [51:0]               q00_reg [2];
    logic signed [51:0]        q01_reg [2];
    logic signed [49:0]        q11_reg [2];
    logic                      kn6_reg;
    // stage 7
    logic signed [NW-1:0]      ab7_reg [2];
    logic signed [DW-1:0]      aa7_reg [2];
    logic                      kn7_reg;
    // stage 8
    logic signed [NW-1:0]      n8_reg;
    logic signed [DW-1:0]      d8_reg;
    logic                      kn8_reg;
    // stage 9
    logic [CW-1:0]             num9_reg, den9_reg;
    logic                      neg9_reg, dead9_reg;

    logic [NW-1:0]             nmag;
    dr_pkg::dr_tag_t           tag9;
    dr_pkg::dr_tag_t           dtag;
    logic [QB:0]               quot;
    logic [QB:0]               lim, mag_sel;
    logic                      out_valid_reg;
    logic signed [DSW-1:0]     disp_reg, disp_next;
    logic                      dv_reg, dv_next;

    assign adv         = !out_valid_reg || result.ready;
    assign pixel.ready = adv;

    // ---- matrix registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
            begin
                cfg_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                dr_pkg::REG_ROW0_COLS01: cfg_reg[0] <= cfg_data;
                dr_pkg::REG_ROW0_COLS23: cfg_reg[1] <= cfg_data;
                dr_pkg::REG_ROW1_COLS01: cfg_reg[2] <= cfg_data;
                dr_pkg::REG_ROW1_COLS23: cfg_reg[3] <= cfg_data;
                dr_pkg::REG_ROW2_COLS01: cfg_reg[4] <= cfg_data;
                dr_pkg::REG_ROW2_COLS23: cfg_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    for (genvar r = 0; r < 3; r++)
    begin : g_row
        for (genvar c = 0; c < 4; c++)
        begin : g_col
            assign m[r][c] = $signed(cfg_reg[r*2 + c/2][(c%2)*32 +: 32]);
        end
    end

    // 16000 * m for the two projector rows
    for (genvar e = 0; e < 2; e++)
    begin : g_k
        for (genvar c = 0; c < 4; c++)
        begin : g_kc
            assign kc[e][c] = KW'(m[e][c]) * KW'(16000);
        end
    end

    // ---- pipeline valid bits ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[7:0], pixel.valid};
        end
    end

    // ---- datapath ----
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // stage 1: capture
            x1_reg       <= pixel.pixel_col & XMASK;
            y1_reg       <= pixel.pixel_row & XMASK;
            code1_reg[0] <= pixel.code_u;
            code1_reg[1] <= pixel.code_v;
            kn1_reg      <= pixel.u_known & pixel.v_known;

            // stage 2: row-2 coefficients times code
            for (int e = 0; e < 2; e++)
            begin
                for (int c = 0; c < 4; c++)
                begin
                    p2_reg[e][c] <= m[2][c] * $signed({1'b0, code1_reg[e]});
                end
            end
            x2_reg  <= x1_reg;
            y2_reg  <= y1_reg;
            kn2_reg <= kn1_reg;

            // stage 3: linear terms, A = 16000*m_e2 - m22*code
            for (int e = 0; e < 2; e++)
            begin
                t3_reg[e][0] <= TW'(p2_reg[e][0]) - TW'(kc[e][0]);
                t3_reg[e][1] <= TW'(p2_reg[e][1]) - TW'(kc[e][1]);
                t3_reg[e][2] <= TW'(kc[e][2]) - TW'(p2_reg[e][2]);
                t3_reg[e][3] <= TW'(p2_reg[e][3]) - TW'(kc[e][3]);
            end
            x3_reg  <= x2_reg;
            y3_reg  <= y2_reg;
            kn3_reg <= kn2_reg;

            // stage 4: coordinate products, terms split at bit 26
            for (int e = 0; e < 2; e++)
            begin
                xh4_reg[e] <= $signed(t3_reg[e][0][TW-1:26]) * $signed({1'b0, x3_reg});
                xl4_reg[e] <= t3_reg[e][0][25:0] * x3_reg;
                yh4_reg[e] <= $signed(t3_reg[e][1][TW-1:26]) * $signed({1'b0, y3_reg});
                yl4_reg[e] <= t3_reg[e][1][25:0] * y3_reg;
                c34_reg[e] <= C3W'(t3_reg[e][3]) * C3W'(1000);
                a4_reg[e]  <= t3_reg[e][2];
            end
            kn4_reg <= kn3_reg;

            // stage 5: B
            for (int e = 0; e < 2; e++)
            begin
                b5_reg[e] <= $signed(((BW'(xh4_reg[e]) + BW'(yh4_reg[e])) << 26)
                             + BW'(xl4_reg[e]) + BW'(yl4_reg[e]) + BW'(c34_reg[e]));
                a5_reg[e] <= a4_reg[e];
            end
            kn5_reg <= kn4_reg;

            // stage 6: A = a1:a0 (split at 26), B = b1:b0 (split at 35)
            for (int e = 0; e < 2; e++)
            begin
                p00_reg[e] <= a5_reg[e][25:0] * b5_reg[e][34:0];
                p01_reg[e] <= $signed({1'b0, a5_reg[e][25:0]}) * $signed(b5_reg[e][BW-1:35]);
                p10_reg[e] <= $signed(a5_reg[e][TW-1:26]) * $signed({1'b0, b5_reg[e][34:0]});
                p11_reg[e] <= $signed(a5_reg[e][TW-1:26]) * $signed(b5_reg[e][BW-1:35]);
                q00_reg[e] <= a5_reg[e][25:0] * a5_reg[e][25:0];
                q01_reg[e] <= $signed({1'b0, a5_reg[e][25:0]}) * $signed(a5_reg[e][TW-1:26]);
                q11_reg[e] <= $signed(a5_reg[e][TW-1:26]) * $signed(a5_reg[e][TW-1:26]);
            end
            kn6_reg <= kn5_reg;

            // stage 7: recombine A*B and A*A
            for (int e = 0; e < 2; e++)
            begin
                ab7_reg[e] <= (NW'(p11_reg[e]) << 61) + (NW'(p01_reg[e]) << 35)
                              + (NW'(p10_reg[e]) << 26) + NW'(p00_reg[e]);
                aa7_reg[e] <= (DW'(q11_reg[e]) << 52) + (DW'(q01_reg[e]) << 27)
                              + DW'(q00_reg[e]);
            end
            kn7_reg <= kn6_reg;

            // stage 8: N and D
            n8_reg  <= ab7_reg[0] + ab7_reg[1];
            d8_reg  <= aa7_reg[0] + aa7_reg[1];
            kn8_reg <= kn7_reg;

            // stage 9: |8N| and 5D for the divider
            num9_reg  <= CW'({nmag, 3'b000});
            den9_reg  <= (CW'($unsigned(d8_reg)) << 2) + CW'($unsigned(d8_reg));
            neg9_reg  <= n8_reg[NW-1];
            dead9_reg <= !kn8_reg || (d8_reg == '0);
        end
    end

    assign nmag = n8_reg[NW-1] ? NW'(-n8_reg) : NW'($unsigned(n8_reg));

    always_comb
    begin
        tag9.valid = vld_reg[8];
        tag9.neg   = neg9_reg;
        tag9.dead  = dead9_reg;
        tag9.sat   = 1'b0;
    end

    dr_div u_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (adv),
        .tag_i  (tag9),
        .num_i  (num9_reg),
        .den_i  (den9_reg),
        .tag_o  (dtag),
        .quot_o (quot)
    );

    // ---- clamp and output register ----
    always_comb
    begin
        lim = dtag.neg ? dr_pkg::LIM_NEG : dr_pkg::LIM_POS;
        mag_sel = (dtag.sat || (quot > lim)) ? lim : quot;
        if (dtag.dead)
        begin
            disp_next = '0;
            dv_next   = 1'b0;
        end
        else
        begin
            disp_next = dtag.neg ? DSW'(-mag_sel) : DSW'(mag_sel);
            dv_next   = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dtag.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            disp_reg <= disp_next;
            dv_reg   <= dv_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.disparity  = disp_reg;
    assign result.disp_valid = dv_reg;

    // ---- assertions ----
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.disp_valid) |-> (result.disparity == '0))
        else $error("invalid result word carries a nonzero disparity");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(vld_reg))
        else $error("pipeline moved while the output was stalled");

    a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.ready) |-> !pixel.ready)
        else $error("pixel accepted while the result word was stalled");

endmodule
`default_nettype wire
